>>> rtl/nrmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmi_pkg
// Shared types and codes of the nearest-row missing imputation unit.
// ----------------------------------------------------------------------------
package nrmi_pkg;

  localparam int VAL_W  = 16;
  localparam int WORD_W = 32;
  localparam int GRP_W  = 8;
  localparam int KEY_W  = 17;
  localparam int IDX_W  = 6;
  localparam int MC_W   = 7;

  localparam logic [KEY_W-1:0] KEY_NONE = 17'h10000;

  localparam logic [1:0] OP_SET_GROUP = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_RUN       = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  localparam logic REG_MARKER_COUNT = 1'b0;
  localparam logic REG_TARGET_GROUP = 1'b1;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic              missing;
    logic [VAL_W-1:0]  value;
    logic [WORD_W-1:0] lod;
    logic [WORD_W-1:0] lkhd;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_G_ISS,
    S_G_CAP,
    S_ROW,
    S_SCAN_ISS,
    S_SCAN_CAP,
    S_RK_CAND,
    S_RK_ISS,
    S_RK_A,
    S_RK_B,
    S_RK_DIV,
    S_RK_WAIT,
    S_FL_ISS,
    S_FL_CHK,
    S_FS_ISS,
    S_FS_CAP,
    S_FL_COPY
  } state_t;

endpackage

>>> rtl/nearest_row_missing_imputation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_row_missing_imputation_unit
// Fills missing cells of a square matrix from the nearest row of the group.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. Group sets and cell
// writes give no result. A cell read passes the registered RAM read and the
// S_READ state and gives its result on done. A run sweeps the group table,
// then walks rows through the single cell memory port: it scans a row, ranks
// each other group row over the group columns with a serial divide, and
// scans the candidates per missing cell to pick a source, so a run grows
// with the cube of the marker count. done pulses for one cycle and cannot
// be held off; results must be taken in that cycle.
module nearest_row_missing_imputation_unit #(
  parameter int MAX_MARKERS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [5:0]  row_index,
  input  logic [5:0]  col_index,
  input  logic [15:0] cell_value,
  input  logic        cell_missing,
  input  logic [31:0] lod_word,
  input  logic [31:0] lkhd_word,
  input  logic [7:0]  group_id,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic        result_kind,
  output logic [15:0] out_value,
  output logic        out_missing,
  output logic [31:0] out_lod,
  output logic [31:0] out_lkhd,
  output logic        run_status,
  output logic [5:0]  fail_row,
  output logic [5:0]  fail_col
);

  localparam int IW = $clog2(MAX_MARKERS);
  localparam int CW = $clog2(MAX_MARKERS + 1);
  localparam int MW = (CW > nrmi_pkg::MC_W) ? CW : nrmi_pkg::MC_W;
  localparam int SW = nrmi_pkg::VAL_W + CW;
  localparam int KW = nrmi_pkg::KEY_W;

  nrmi_pkg::state_t state, state_next;

  logic [nrmi_pkg::MC_W-1:0] marker_count;
  logic [7:0]                target_group;
  logic [MAX_MARKERS-1:0]    flags, flags_next;
  logic [CW-1:0] row, row_next, col, col_next, cand, cand_next, best, best_next;
  logic [SW-1:0] sum, sum_next;
  logic [CW-1:0] used, used_next;
  logic [nrmi_pkg::VAL_W-1:0] a_val, a_val_next;
  logic          a_miss, a_miss_next;
  logic          found, found_next;
  logic [KW-1:0] bkey, bkey_next;
  logic [CW-1:0] n;

  logic done_next, kind_next, status_next;
  nrmi_pkg::cell_t rd_cell_next;
  logic [5:0] frow_next, fcol_next;

  // memory ports
  logic            cell_we, grp_we, rank_we;
  logic [IW-1:0]   cell_wr, cell_wc, cell_rr, cell_rc;
  nrmi_pkg::cell_t cell_wd, cell_q;
  logic [CW*0+nrmi_pkg::CELL_W-1:0] cell_q_raw;
  logic [IW-1:0]   grp_wa, grp_ra, rank_wa, rank_ra;
  logic [7:0]      grp_wd, grp_q;
  logic [KW-1:0]   rank_wd, rank_q;

  logic          div_start, div_done;
  logic [KW-1:0] div_q;

  logic rok, cok;
  logic [IW-1:0] ri, ci, row_i, col_i, cand_i, best_i;
  logic [nrmi_pkg::VAL_W-1:0] diff;

  assign rok    = int'(row_index) < MAX_MARKERS;
  assign cok    = int'(col_index) < MAX_MARKERS;
  assign ri     = IW'(row_index);
  assign ci     = IW'(col_index);
  assign row_i  = row[IW-1:0];
  assign col_i  = col[IW-1:0];
  assign cand_i = cand[IW-1:0];
  assign best_i = best[IW-1:0];
  assign cell_q = nrmi_pkg::cell_t'(cell_q_raw);
  assign diff   = (a_val > cell_q.value) ? a_val - cell_q.value : cell_q.value - a_val;
  assign n      = (MW'(marker_count) >= MW'(MAX_MARKERS)) ? CW'(MAX_MARKERS)
                                                           : CW'(marker_count);
  assign busy   = state != nrmi_pkg::S_IDLE;

  nrmi_ram #(.W(nrmi_pkg::CELL_W), .AW(2 * IW)) u_cell (
    .clk(clk), .we(cell_we), .waddr({cell_wr, cell_wc}), .wdata(cell_wd),
    .raddr({cell_rr, cell_rc}), .rdata(cell_q_raw)
  );

  nrmi_ram #(.W(nrmi_pkg::GRP_W), .AW(IW)) u_grp (
    .clk(clk), .we(grp_we), .waddr(grp_wa), .wdata(grp_wd),
    .raddr(grp_ra), .rdata(grp_q)
  );

  nrmi_ram #(.W(KW), .AW(IW)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd),
    .raddr(rank_ra), .rdata(rank_q)
  );

  nrmi_div #(.SW(SW), .DW(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum), .divisor(used),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next   = state;
    flags_next   = flags;
    row_next     = row;
    col_next     = col;
    cand_next    = cand;
    best_next    = best;
    sum_next     = sum;
    used_next    = used;
    a_val_next   = a_val;
    a_miss_next  = a_miss;
    found_next   = found;
    bkey_next    = bkey;
    done_next    = 1'b0;
    kind_next    = nrmi_pkg::KIND_READ;
    status_next  = 1'b0;
    rd_cell_next = '0;
    frow_next    = '0;
    fcol_next    = '0;
    cell_we      = 1'b0;
    cell_wr      = ri;
    cell_wc      = ci;
    cell_wd      = '{missing: cell_missing, value: cell_value, lod: lod_word,
                     lkhd: lkhd_word};
    cell_rr      = ri;
    cell_rc      = ci;
    grp_we       = 1'b0;
    grp_wa       = ri;
    grp_wd       = group_id;
    grp_ra       = col_i;
    rank_we      = 1'b0;
    rank_wa      = cand_i;
    rank_wd      = div_q;
    rank_ra      = cand_i;
    div_start    = 1'b0;

    unique case (state)
      nrmi_pkg::S_IDLE: begin
        if (start) begin
          unique case (opcode)
            nrmi_pkg::OP_SET_GROUP: grp_we = rok;
            nrmi_pkg::OP_WRITE:     cell_we = rok && cok;
            nrmi_pkg::OP_RUN: begin
              col_next   = '0;
              state_next = nrmi_pkg::S_G_ISS;
            end
            nrmi_pkg::OP_READ: begin
              if (rok && cok) begin
                state_next = nrmi_pkg::S_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      nrmi_pkg::S_READ: begin
        done_next    = 1'b1;
        rd_cell_next = cell_q;
        state_next   = nrmi_pkg::S_IDLE;
      end
      // build group membership flags
      nrmi_pkg::S_G_ISS: begin
        if (col == n) begin
          row_next   = '0;
          state_next = nrmi_pkg::S_ROW;
        end else begin
          state_next = nrmi_pkg::S_G_CAP;
        end
      end
      nrmi_pkg::S_G_CAP: begin
        flags_next[col_i] = grp_q == target_group;
        col_next   = col + 1'b1;
        state_next = nrmi_pkg::S_G_ISS;
      end
      nrmi_pkg::S_ROW: begin
        if (row == n) begin
          done_next  = 1'b1;
          kind_next  = nrmi_pkg::KIND_STATUS;
          state_next = nrmi_pkg::S_IDLE;
        end else if (!flags[row_i]) begin
          row_next = row + 1'b1;
        end else begin
          col_next   = '0;
          state_next = nrmi_pkg::S_SCAN_ISS;
        end
      end
      nrmi_pkg::S_SCAN_ISS: begin
        cell_rr = row_i;
        cell_rc = col_i;
        if (col == n) begin
          row_next   = row + 1'b1;
          state_next = nrmi_pkg::S_ROW;
        end else if (!flags[col_i]) begin
          col_next = col + 1'b1;
        end else begin
          state_next = nrmi_pkg::S_SCAN_CAP;
        end
      end
      nrmi_pkg::S_SCAN_CAP: begin
        if (cell_q.missing) begin
          cand_next  = '0;
          state_next = nrmi_pkg::S_RK_CAND;
        end else begin
          col_next   = col + 1'b1;
          state_next = nrmi_pkg::S_SCAN_ISS;
        end
      end
      // rank every other group row against this one
      nrmi_pkg::S_RK_CAND: begin
        if (cand == n) begin
          col_next   = '0;
          state_next = nrmi_pkg::S_FL_ISS;
        end else if (!flags[cand_i] || cand == row) begin
          cand_next = cand + 1'b1;
        end else begin
          sum_next   = '0;
          used_next  = '0;
          col_next   = '0;
          state_next = nrmi_pkg::S_RK_ISS;
        end
      end
      nrmi_pkg::S_RK_ISS: begin
        cell_rr = row_i;
        cell_rc = col_i;
        if (col == n) begin
          state_next = nrmi_pkg::S_RK_DIV;
        end else if (!flags[col_i]) begin
          col_next = col + 1'b1;
        end else begin
          state_next = nrmi_pkg::S_RK_A;
        end
      end
      nrmi_pkg::S_RK_A: begin
        a_val_next  = cell_q.value;
        a_miss_next = cell_q.missing;
        cell_rr     = cand_i;
        cell_rc     = col_i;
        state_next  = nrmi_pkg::S_RK_B;
      end
      nrmi_pkg::S_RK_B: begin
        if (!a_miss && !cell_q.missing) begin
          sum_next  = sum + SW'(diff);
          used_next = used + 1'b1;
        end
        col_next   = col + 1'b1;
        state_next = nrmi_pkg::S_RK_ISS;
      end
      nrmi_pkg::S_RK_DIV: begin
        if (used == '0) begin
          rank_we    = 1'b1;
          rank_wd    = nrmi_pkg::KEY_NONE;
          cand_next  = cand + 1'b1;
          state_next = nrmi_pkg::S_RK_CAND;
        end else begin
          div_start  = 1'b1;
          state_next = nrmi_pkg::S_RK_WAIT;
        end
      end
      nrmi_pkg::S_RK_WAIT: begin
        if (div_done) begin
          rank_we    = 1'b1;
          cand_next  = cand + 1'b1;
          state_next = nrmi_pkg::S_RK_CAND;
        end
      end
      // fill the missing cells of this row
      nrmi_pkg::S_FL_ISS: begin
        cell_rr = row_i;
        cell_rc = col_i;
        if (col == n) begin
          row_next   = row + 1'b1;
          state_next = nrmi_pkg::S_ROW;
        end else if (!flags[col_i]) begin
          col_next = col + 1'b1;
        end else begin
          state_next = nrmi_pkg::S_FL_CHK;
        end
      end
      nrmi_pkg::S_FL_CHK: begin
        if (!cell_q.missing) begin
          col_next   = col + 1'b1;
          state_next = nrmi_pkg::S_FL_ISS;
        end else begin
          found_next = 1'b0;
          cand_next  = '0;
          state_next = nrmi_pkg::S_FS_ISS;
        end
      end
      nrmi_pkg::S_FS_ISS: begin
        cell_rr = cand_i;
        cell_rc = col_i;
        if (cand == n) begin
          cell_rr = best_i;
          if (!found) begin
            done_next   = 1'b1;
            kind_next   = nrmi_pkg::KIND_STATUS;
            status_next = 1'b1;
            frow_next   = 6'(row_i);
            fcol_next   = 6'(col_i);
            state_next  = nrmi_pkg::S_IDLE;
          end else begin
            state_next = nrmi_pkg::S_FL_COPY;
          end
        end else if (!flags[cand_i] || cand == row) begin
          cand_next = cand + 1'b1;
        end else begin
          state_next = nrmi_pkg::S_FS_CAP;
        end
      end
      nrmi_pkg::S_FS_CAP: begin
        if (!cell_q.missing && (!found || rank_q < bkey)) begin
          found_next = 1'b1;
          best_next  = cand;
          bkey_next  = rank_q;
        end
        cand_next  = cand + 1'b1;
        state_next = nrmi_pkg::S_FS_ISS;
      end
      nrmi_pkg::S_FL_COPY: begin
        cell_we    = 1'b1;
        cell_wr    = row_i;
        cell_wc    = col_i;
        cell_wd    = cell_q;
        col_next   = col + 1'b1;
        state_next = nrmi_pkg::S_FL_ISS;
      end
      default: state_next = nrmi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nrmi_pkg::S_IDLE;
      done         <= 1'b0;
      marker_count <= 7'd64;
      target_group <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        unique case (cfg_index)
          nrmi_pkg::REG_MARKER_COUNT: marker_count <= cfg_data[nrmi_pkg::MC_W-1:0];
          nrmi_pkg::REG_TARGET_GROUP: target_group <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    flags       <= flags_next;
    row         <= row_next;
    col         <= col_next;
    cand        <= cand_next;
    best        <= best_next;
    sum         <= sum_next;
    used        <= used_next;
    a_val       <= a_val_next;
    a_miss      <= a_miss_next;
    found       <= found_next;
    bkey        <= bkey_next;
    result_kind <= kind_next;
    out_value   <= rd_cell_next.value;
    out_missing <= rd_cell_next.missing;
    out_lod     <= rd_cell_next.lod;
    out_lkhd    <= rd_cell_next.lkhd;
    run_status  <= status_next;
    fail_row    <= frow_next;
    fail_col    <= fcol_next;
  end

endmodule

>>> rtl/nrmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmi_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nrmi_ram #(
  parameter int W  = 8,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nrmi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmi_div
// Restoring divider, one quotient bit per cycle, truncated quotient.
// ----------------------------------------------------------------------------
module nrmi_div #(
  parameter int SW = 22,
  parameter int DW = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [SW-1:0]            dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     done,
  output logic [nrmi_pkg::KEY_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SW + 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [SW-1:0]    dvd;
  logic [SW-1:0]    quo;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem, dvd[SW-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = quo[nrmi_pkg::KEY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dvd <= dividend;
      quo <= '0;
    end else if (active) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      dvd <= {dvd[SW-2:0], 1'b0};
      quo <= {quo[SW-2:0], fits};
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the nearest-row imputation unit against a behavioral predictor.
// Loads, group sets, cell reads and imputation runs are driven over several
// marker count / target group settings, with random start gaps; every read
// and run status coming back on done is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import nrmi_pkg::*;

  localparam int NM = 64;
  localparam int BLK = 12;          // markers that take part in imputation
  localparam int IDLE_LIMIT = 400000;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic        missing;
    logic [31:0] lod;
    logic [31:0] lkhd;
    logic        status;
    logic [5:0]  frow;
    logic [5:0]  fcol;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  r;
    logic [5:0]  c;
    logic [15:0] v;
    logic        m;
    logic [31:0] lod;
    logic [31:0] lkhd;
    logic [7:0]  g;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = OP_READ;
  logic [5:0] row_index = '0;
  logic [5:0] col_index = '0;
  logic [15:0] cell_value = '0;
  logic cell_missing = 1'b0;
  logic [31:0] lod_word = '0;
  logic [31:0] lkhd_word = '0;
  logic [7:0] group_id = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_MARKER_COUNT;
  logic [7:0] cfg_data = '0;
  logic done;
  logic result_kind;
  logic [15:0] out_value;
  logic out_missing;
  logic [31:0] out_lod;
  logic [31:0] out_lkhd;
  logic run_status;
  logic [5:0] fail_row;
  logic [5:0] fail_col;

  nearest_row_missing_imputation_unit u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow matrix and configuration
  cell_t       shadow_cell [NM][NM];
  bit          cell_known [NM][NM];
  logic [7:0]  shadow_group [NM];
  logic [16:0] row_key [NM];
  logic [6:0]  shadow_count = 7'd64;
  logic [7:0]  shadow_target = 8'd0;

  logic [6:0] phase_count [6] = '{7'd12, 7'd12, 7'd64, 7'd1, 7'd7, 7'd12};
  logic [7:0] phase_target [6] = '{8'd0, 8'd1, 8'hff, 8'd0, 8'd2, 8'hff};

  result_t pending_results[$];
  int errors = 0;
  int n_read = 0, n_run = 0, n_fail = 0, n_cmd = 0;
  int idle_cycles = 0;

  function automatic int active_markers();
    return (shadow_count > NM) ? NM : int'(shadow_count);
  endfunction

  function automatic bit member(int m);
    return shadow_group[m] == shadow_target;
  endfunction

  function automatic void rank_candidates(int row, int n);
    int unsigned sum, used, a, b;
    for (int cand = 0; cand < n; cand++) begin
      if (!member(cand) || cand == row) continue;
      sum = 0;
      used = 0;
      for (int c = 0; c < n; c++) begin
        if (!member(c) || shadow_cell[row][c].missing || shadow_cell[cand][c].missing)
          continue;
        a = 32'(shadow_cell[row][c].value);
        b = 32'(shadow_cell[cand][c].value);
        sum += (a > b) ? a - b : b - a;
        used++;
      end
      row_key[cand] = used ? 17'(sum / used) : KEY_NONE;
    end
  endfunction

  function automatic result_t impute_group();
    result_t res;
    int n, best;
    bit any, found;
    logic [16:0] bkey;
    res = '0;
    res.kind = KIND_STATUS;
    n = active_markers();
    for (int row = 0; row < n; row++) begin
      if (!member(row)) continue;
      any = 0;
      for (int c = 0; c < n; c++)
        if (member(c) && shadow_cell[row][c].missing) any = 1;
      if (!any) continue;
      rank_candidates(row, n);
      for (int c = 0; c < n; c++) begin
        if (!member(c) || !shadow_cell[row][c].missing) continue;
        found = 0;
        best = 0;
        bkey = '0;
        for (int cand = 0; cand < n; cand++) begin
          if (!member(cand) || cand == row || shadow_cell[cand][c].missing) continue;
          if (!found || row_key[cand] < bkey) begin
            found = 1;
            best = cand;
            bkey = row_key[cand];
          end
        end
        if (!found) begin
          res.status = 1'b1;
          res.frow = 6'(row);
          res.fcol = 6'(c);
          return res;
        end
        shadow_cell[row][c] = shadow_cell[best][c];
      end
    end
    return res;
  endfunction

  // a run may only touch cells that have been written
  function automatic bit run_is_safe();
    int n;
    n = active_markers();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (member(r) && member(c) && !cell_known[r][c]) return 0;
    return 1;
  endfunction

  function automatic result_t apply_cmd(cmd_t cmd);
    result_t res;
    res = '0;
    case (cmd.op)
      OP_SET_GROUP: shadow_group[cmd.r] = cmd.g;
      OP_WRITE: begin
        shadow_cell[cmd.r][cmd.c] = '{missing: cmd.m, value: cmd.v, lod: cmd.lod,
                                      lkhd: cmd.lkhd};
        cell_known[cmd.r][cmd.c] = 1;
      end
      OP_RUN: res = impute_group();
      default: begin
        res.kind = KIND_READ;
        res.value = shadow_cell[cmd.r][cmd.c].value;
        res.missing = shadow_cell[cmd.r][cmd.c].missing;
        res.lod = shadow_cell[cmd.r][cmd.c].lod;
        res.lkhd = shadow_cell[cmd.r][cmd.c].lkhd;
      end
    endcase
    return res;
  endfunction

  // drive one command and wait for the transaction; typed expectation optional
  task automatic issue(cmd_t cmd, bit typed = 0, result_t typed_res = '0);
    int gap;
    result_t res;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= cmd.op;
    row_index <= cmd.r;
    col_index <= cmd.c;
    cell_value <= cmd.v;
    cell_missing <= cmd.m;
    lod_word <= cmd.lod;
    lkhd_word <= cmd.lkhd;
    group_id <= cmd.g;
    do @(posedge clk); while (busy);
    n_cmd++;
    res = apply_cmd(cmd);
    if (cmd.op == OP_RUN) begin
      n_run++;
      if (res.status) n_fail++;
    end
    if (cmd.op == OP_READ) n_read++;
    if (cmd.op == OP_RUN || cmd.op == OP_READ)
      pending_results.insert(pending_results.size(), typed ? typed_res : res);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MARKER_COUNT) shadow_count = data[6:0];
    else shadow_target = data;
  endtask

  function automatic cmd_t random_cmd(int run_pct);
    cmd_t cmd;
    int pick, k;
    cmd = '0;
    cmd.v = 16'($urandom());
    cmd.lod = $urandom();
    cmd.lkhd = $urandom();
    cmd.m = ($urandom_range(0, 3) == 0);
    cmd.g = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < run_pct) cmd.op = OP_RUN;
    else if (pick < 55) cmd.op = OP_WRITE;
    else if (pick < 90) cmd.op = OP_READ;
    else cmd.op = OP_SET_GROUP;
    case (cmd.op)
      OP_WRITE: begin
        if ($urandom_range(0, 9) < 8) begin
          cmd.r = 6'($urandom_range(0, BLK - 1));
          cmd.c = 6'($urandom_range(0, BLK - 1));
        end else begin
          cmd.r = 6'($urandom());
          cmd.c = 6'($urandom());
        end
        if ($urandom_range(0, 7) == 0) cmd.v = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end
      OP_SET_GROUP: begin
        if ($urandom_range(0, 1)) begin
          cmd.r = 6'($urandom_range(0, BLK - 1));
          k = $urandom_range(0, 3);
          cmd.g = (k == 3) ? 8'hff : 8'(k);
        end else begin
          cmd.r = 6'($urandom_range(BLK, NM - 1));
          cmd.g = 8'($urandom_range(100, 254));
        end
      end
      default: ;
    endcase
    // reads go to known cells only, otherwise fall back to the top-left cell
    if (cmd.op == OP_READ) begin
      cmd.r = 6'($urandom_range(0, BLK - 1));
      cmd.c = 6'($urandom_range(0, BLK - 1));
      if ($urandom_range(0, 3) == 0) begin
        cmd.r = 6'($urandom());
        cmd.c = 6'($urandom());
      end
      if (!cell_known[cmd.r][cmd.c]) begin
        cmd.r = '0;
        cmd.c = '0;
      end
    end
    if (cmd.op == OP_RUN && !run_is_safe()) begin
      cmd.op = OP_READ;
      cmd.r = '0;
      cmd.c = '0;
    end
    return cmd;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && done) begin
      got = '{result_kind, out_value, out_missing, out_lod, out_lkhd, run_status,
              fail_row, fail_col};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: kind %0d/%0d value %h/%h miss %0d/%0d",
                     want.kind, got.kind, want.value, got.value, want.missing,
                     got.missing);
            $display("  lod %h/%h lkhd %h/%h status %0d/%0d fail %0d,%0d/%0d,%0d",
                     want.lod, got.lod, want.lkhd, got.lkhd, want.status,
                     got.status, want.frow, want.fcol, got.frow, got.fcol);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("tb_top failed");
      $finish;
    end
  end

  cmd_t directed[$];
  result_t directed_res[$];
  bit directed_typed[$];

  task automatic add_row(cmd_t cmd, bit typed, result_t res);
    directed.insert(directed.size(), cmd);
    directed_typed.insert(directed_typed.size(), typed);
    directed_res.insert(directed_res.size(), res);
  endtask

  initial begin
    cmd_t cmd;
    int n_phase;

    for (int m = 0; m < NM; m++) shadow_group[m] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the group table and the working block so runs read defined data
    for (int m = 0; m < NM; m++) begin
      cmd = '0;
      cmd.op = OP_SET_GROUP;
      cmd.r = 6'(m);
      cmd.g = (m < BLK) ? 8'(m % 3) : 8'(100 + m);
      issue(cmd);
    end
    for (int r = 0; r < BLK; r++)
      for (int c = 0; c < BLK; c++) begin
        cmd = '0;
        cmd.op = OP_WRITE;
        cmd.r = 6'(r);
        cmd.c = 6'(c);
        cmd.v = 16'($urandom());
        cmd.m = ($urandom_range(0, 4) == 0);
        cmd.lod = $urandom();
        cmd.lkhd = $urandom();
        issue(cmd);
      end

    // directed rows: extremes, every opcode, a lone member that cannot be filled
    add_row('{OP_WRITE, 6'd63, 6'd63, 16'hffff, 1'b1, 32'hffffffff, 32'hffffffff, 8'h00},
            0, '0);
    add_row('{OP_READ, 6'd63, 6'd63, 16'h0, 1'b0, 32'h0, 32'h0, 8'h0}, 1,
            '{KIND_READ, 16'hffff, 1'b1, 32'hffffffff, 32'hffffffff, 1'b0, 6'd0, 6'd0});
    add_row('{OP_WRITE, 6'd63, 6'd0, 16'h0000, 1'b0, 32'h0, 32'h0, 8'hff}, 0, '0);
    add_row('{OP_READ, 6'd63, 6'd0, 16'hffff, 1'b1, 32'hffffffff, 32'hffffffff, 8'hff}, 1,
            '{KIND_READ, 16'h0, 1'b0, 32'h0, 32'h0, 1'b0, 6'd0, 6'd0});
    add_row('{OP_WRITE, 6'd0, 6'd63, 16'h8001, 1'b0, 32'ha5a55a5a, 32'h5a5aa5a5, 8'h0},
            0, '0);
    add_row('{OP_READ, 6'd0, 6'd63, 16'h0, 1'b0, 32'h0, 32'h0, 8'h0}, 1,
            '{KIND_READ, 16'h8001, 1'b0, 32'ha5a55a5a, 32'h5a5aa5a5, 1'b0, 6'd0, 6'd0});
    add_row('{OP_SET_GROUP, 6'd63, 6'd0, 16'h0, 1'b0, 32'h0, 32'h0, 8'hfe}, 0, '0);
    add_row('{OP_SET_GROUP, 6'd11, 6'd0, 16'h0, 1'b0, 32'h0, 32'h0, 8'hff}, 0, '0);
    add_row('{OP_WRITE, 6'd11, 6'd11, 16'h1234, 1'b1, 32'h1, 32'h2, 8'h0}, 0, '0);
    // two equal rows tie, a row with no shared present column ranks last
    add_row('{OP_WRITE, 6'd0, 6'd3, 16'h0100, 1'b0, 32'h11, 32'h12, 8'h0}, 0, '0);
    add_row('{OP_WRITE, 6'd3, 6'd3, 16'h0100, 1'b0, 32'h31, 32'h32, 8'h0}, 0, '0);
    add_row('{OP_WRITE, 6'd6, 6'd0, 16'h0000, 1'b1, 32'h61, 32'h62, 8'h0}, 0, '0);
    add_row('{OP_WRITE, 6'd0, 6'd0, 16'h0000, 1'b1, 32'h01, 32'h02, 8'h0}, 0, '0);
    add_row('{OP_RUN, 6'd0, 6'd0, 16'h0, 1'b0, 32'h0, 32'h0, 8'h0}, 0, '0);
    add_row('{OP_READ, 6'd0, 6'd0, 16'h0, 1'b0, 32'h0, 32'h0, 8'h0}, 0, '0);
    add_row('{OP_READ, 6'd6, 6'd0, 16'h0, 1'b0, 32'h0, 32'h0, 8'h0}, 0, '0);
    add_row('{OP_READ, 6'd11, 6'd11, 16'h0, 1'b0, 32'h0, 32'h0, 8'h0}, 0, '0);

    for (int i = 0; i < directed.size(); i++) begin
      cmd = directed[i];
      if (cmd.op == OP_RUN && !run_is_safe()) continue;
      issue(cmd, directed_typed[i], directed_res[i]);
    end

    // marker 11 alone in group 255 with its own cell missing cannot be filled
    write_reg(REG_TARGET_GROUP, 8'hff);
    cmd = '0;
    cmd.op = OP_RUN;
    issue(cmd, 1, '{KIND_STATUS, 16'h0, 1'b0, 32'h0, 32'h0, 1'b1, 6'd11, 6'd11});

    n_phase = 0;
    foreach (phase_count[p]) begin
      write_reg(REG_MARKER_COUNT, {1'b0, phase_count[p]});
      write_reg(REG_TARGET_GROUP, phase_target[p]);
      for (int i = 0; i < 204; i++)
        issue(random_cmd(phase_count[p] == 7'd64 ? 2 : 6));
      n_phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d commands over %0d settings: %0d reads, %0d runs (%0d unfilled)",
             n_cmd, n_phase + 1, n_read, n_run, n_fail);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_results.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
